>>> sv/epdm_pkg.sv
// Shared constants, types and payload structs for the echo pulse distance block.
`timescale 1ns / 1ps
`default_nettype none

package epdm_pkg;

    // Channel and field geometry.
    localparam int NUM_CH      = 4;
    localparam int TIME_BITS   = 32;
    localparam int DIST_BITS   = 24;
    localparam int TEMP_BITS   = 6;
    localparam int RING_DEPTH  = 4;
    localparam int RING_BITS   = $clog2(RING_DEPTH);

    // Speed of sound factor: SPEED_BASE + SPEED_PER_DEG * temperature, at most 3693.
    localparam int FACTOR_BITS = 12;
    localparam logic [FACTOR_BITS-1:0] SPEED_BASE    = FACTOR_BITS'(3315);
    localparam logic [FACTOR_BITS-1:0] SPEED_PER_DEG = FACTOR_BITS'(6);
    localparam logic [TEMP_BITS-1:0]   TEMP_RESET    = TEMP_BITS'(20);
    localparam logic [FACTOR_BITS-1:0] FACTOR_RESET  = FACTOR_BITS'(3315 + 6 * 20);

    // Division by 1600 is a shift by 6 followed by a division by 25.
    localparam int SCALE_DIV   = 1600;
    localparam int SCALE_SHIFT = 6;
    localparam int SCALE_ODD   = SCALE_DIV >> SCALE_SHIFT;
    localparam int PROD_BITS   = TIME_BITS + FACTOR_BITS;

    // Below the saturation limit the shifted product is under 25 * 2^DIST_BITS.
    localparam int QUOT_BITS   = DIST_BITS + 5;
    localparam int RECIP_SHIFT = QUOT_BITS + 5;
    localparam int RECIP_BITS  = RECIP_SHIFT - 4;
    localparam int RPROD_BITS  = QUOT_BITS + RECIP_BITS;

    localparam logic [PROD_BITS-1:0] SAT_LIMIT =
        PROD_BITS'(longint'(SCALE_DIV) << DIST_BITS);
    localparam logic [RECIP_BITS-1:0] RECIP =
        RECIP_BITS'(((longint'(1) << RECIP_SHIFT) + longint'(SCALE_ODD - 1))
                    / longint'(SCALE_ODD));
    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    // Stream widths, rounded up to whole bytes.
    localparam int S_TDATA_BITS = ((NUM_CH + TIME_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((NUM_CH + NUM_CH * DIST_BITS + 7) / 8) * 8;

    typedef logic [TIME_BITS-1:0]  time_t;
    typedef logic [DIST_BITS-1:0]  dist_t;
    typedef logic [PROD_BITS-1:0]  prod_t;
    typedef logic [RPROD_BITS-1:0] rprod_t;

    // Falling edge mask and the measured pulse width of every channel.
    typedef struct packed {
        logic [NUM_CH-1:0]       mask;
        time_t [NUM_CH-1:0]      width;
    } width_item_t;

    // Falling edge mask and the new distance of every channel.
    typedef struct packed {
        logic [NUM_CH-1:0]       mask;
        dist_t [NUM_CH-1:0]      distance;
    } dist_item_t;

endpackage

`default_nettype wire

>>> sv/echo_pulse_distance_median4.sv
// Top level of the four-channel echo pulse distance capture with middle-two filtering.
//
// Usage: the slave stream carries one transaction per clock: the four echo line
// levels and a free-running 32-bit timestamp. A rising edge on a channel records
// its start time; a falling edge measures the pulse width, converts it to
// micrometres with the speed of sound for the configured temperature, saturates
// it to 24 bits and pushes it into that channel's four-entry ring. The channel's
// filtered distance is the floor average of the two middle ring values.
// A master transaction is produced only for input transactions with at least one
// falling edge; it carries the updated channel mask and all four held distances.
// The pipeline takes one transaction every cycle unless the receiver stalls; its stages
// are input register, width, multiply, reciprocal, ring and result register.
// Transactions without a falling edge leave no result.
// The temperature register is written through cfg_wr_en / cfg_wr_data while idle.
// Reset clears start times, rings, held distances and edge state, and sets the
// temperature to 20 degrees C. When the receiver stalls, results back up through
// the stages and s_tready falls only once every stage holds a transaction.
`timescale 1ns / 1ps
`default_nettype none

module echo_pulse_distance_median4
    import epdm_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // [3:0] echo_levels, [35:4] now_time, upper bits zero
    input  wire logic [S_TDATA_BITS-1:0] s_tdata,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // [3:0] updated_channels, then median_ch0 .. median_ch3 of 24 bits each, upper bits zero
    output logic [M_TDATA_BITS-1:0]      m_tdata,
    input  wire logic                    cfg_wr_en,
    input  wire logic [TEMP_BITS-1:0]    cfg_wr_data
);

    logic [TEMP_BITS-1:0] temperature_reg;

    logic                 width_valid;
    logic                 width_ready;
    width_item_t          width_item;
    logic                 dist_valid;
    logic                 dist_ready;
    dist_item_t           dist_item;

    // Temperature register; the full 6-bit value feeds the speed factor.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temperature_reg <= TEMP_RESET;
        end else if (cfg_wr_en) begin
            temperature_reg <= cfg_wr_data;
        end
    end

    // Edge detection and pulse width measurement.
    epdm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_levels (s_tdata[NUM_CH-1:0]),
        .in_time   (s_tdata[NUM_CH +: TIME_BITS]),
        .out_valid (width_valid),
        .out_ready (width_ready),
        .out_item  (width_item)
    );

    // Conversion of widths to saturated distances in micrometres.
    epdm_scale u_scale (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .temperature (temperature_reg),
        .in_valid    (width_valid),
        .in_ready    (width_ready),
        .in_item     (width_item),
        .out_valid   (dist_valid),
        .out_ready   (dist_ready),
        .out_item    (dist_item)
    );

    // Ring storage, filtering and the result register.
    epdm_filter u_filter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (dist_valid),
        .in_ready (dist_ready),
        .in_item  (dist_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

>>> sv/epdm_front.sv
// Input register, echo edge detection, start time capture and pulse width measurement.
`timescale 1ns / 1ps
`default_nettype none

module epdm_front
    import epdm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [NUM_CH-1:0] in_levels,
    input  wire time_t             in_time,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output width_item_t            out_item
);

    logic              in_v_reg;
    logic [NUM_CH-1:0] in_levels_reg;
    time_t             in_time_reg;
    logic [NUM_CH-1:0] prev_reg;
    time_t             rise_reg [NUM_CH];
    logic              w_v_reg;
    width_item_t       w_item_reg;

    logic [NUM_CH-1:0] rise_edge;
    logic [NUM_CH-1:0] fall_edge;
    logic              w_ok;
    logic              in_go;
    width_item_t       w_item_next;

    assign rise_edge = in_levels_reg & ~prev_reg;
    assign fall_edge = ~in_levels_reg & prev_reg;

    // An item without a falling edge only updates the edge state and start times and is dropped.
    assign w_ok     = !w_v_reg || out_ready;
    assign in_go    = in_v_reg && ((fall_edge == '0) || w_ok);
    assign in_ready = !in_v_reg || in_go;

    always_comb begin
        w_item_next.mask = fall_edge;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            w_item_next.width[ch] = in_time_reg - rise_reg[ch];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
            prev_reg <= '0;
            w_v_reg  <= 1'b0;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                rise_reg[ch] <= '0;
            end
        end else begin
            if (in_ready) begin
                in_v_reg <= in_valid;
            end
            if (in_go) begin
                prev_reg <= in_levels_reg;
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    if (rise_edge[ch]) begin
                        rise_reg[ch] <= in_time_reg;
                    end
                end
            end
            if (w_ok) begin
                w_v_reg <= in_go && (fall_edge != '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            in_levels_reg <= in_levels;
            in_time_reg   <= in_time;
        end
        if (w_ok) begin
            w_item_reg <= w_item_next;
        end
    end

    assign out_valid = w_v_reg;
    assign out_item  = w_item_reg;

endmodule

`default_nettype wire

>>> sv/epdm_scale.sv
// Width to micrometre conversion: speed factor multiply, division by 1600, saturation.
`timescale 1ns / 1ps
`default_nettype none

module epdm_scale
    import epdm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [TEMP_BITS-1:0] temperature,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire width_item_t          in_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output dist_item_t                out_item
);

    logic [FACTOR_BITS-1:0] factor_reg;
    logic [FACTOR_BITS-1:0] factor_next;

    logic              p_v_reg;
    logic [NUM_CH-1:0] p_mask_reg;
    prod_t             p_prod_reg [NUM_CH];
    prod_t             p_prod_next [NUM_CH];

    logic              r_v_reg;
    logic [NUM_CH-1:0] r_mask_reg;
    logic [NUM_CH-1:0] r_sat_reg;
    logic [NUM_CH-1:0] r_sat_next;
    rprod_t            r_prod_reg [NUM_CH];
    rprod_t            r_prod_next [NUM_CH];

    logic              p_ok;
    logic              r_ok;

    assign r_ok     = !r_v_reg || out_ready;
    assign p_ok     = !p_v_reg || r_ok;
    assign in_ready = p_ok;

    // The user changes the temperature only while idle; the block does not enforce it.
    assign factor_next = SPEED_BASE + FACTOR_BITS'(temperature) * SPEED_PER_DEG;

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            p_prod_next[ch] = PROD_BITS'(in_item.width[ch]) * PROD_BITS'(factor_reg);
            r_sat_next[ch]  = (p_prod_reg[ch] >= SAT_LIMIT);
            // Exact division by 25 through a scaled reciprocal, valid below the limit.
            r_prod_next[ch] = RPROD_BITS'(p_prod_reg[ch][SCALE_SHIFT +: QUOT_BITS])
                            * RPROD_BITS'(RECIP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_reg <= FACTOR_RESET;
            p_v_reg    <= 1'b0;
            r_v_reg    <= 1'b0;
        end else begin
            factor_reg <= factor_next;
            if (p_ok) begin
                p_v_reg <= in_valid;
            end
            if (r_ok) begin
                r_v_reg <= p_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p_ok) begin
            p_mask_reg <= in_item.mask;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                p_prod_reg[ch] <= p_prod_next[ch];
            end
        end
        if (r_ok) begin
            r_mask_reg <= p_mask_reg;
            r_sat_reg  <= r_sat_next;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_prod_reg[ch] <= r_prod_next[ch];
            end
        end
    end

    always_comb begin
        out_item.mask = r_mask_reg;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            out_item.distance[ch] = r_sat_reg[ch] ? DIST_MAX
                                                  : r_prod_reg[ch][RECIP_SHIFT +: DIST_BITS];
        end
    end

    assign out_valid = r_v_reg;

endmodule

`default_nettype wire

>>> sv/epdm_filter.sv
// Per-channel distance rings, middle-two average filter and the result register.
`timescale 1ns / 1ps
`default_nettype none

module epdm_filter
    import epdm_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire dist_item_t              in_item,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [M_TDATA_BITS-1:0]      m_tdata
);

    dist_t                             hist_reg [NUM_CH][RING_DEPTH];
    logic [NUM_CH-1:0][RING_BITS-1:0]  slot_reg;
    dist_t                             hold_reg [NUM_CH];
    dist_t                             hold_next [NUM_CH];
    logic                              m_v_reg;
    logic [NUM_CH-1:0]                 m_mask_reg;
    logic                              o_v_reg;
    logic [M_TDATA_BITS-1:0]           o_data_reg;
    logic [M_TDATA_BITS-1:0]           o_data_next;

    logic                              o_ok;
    logic                              mv_ok;
    logic                              in_acc;

    // Average of the two middle values: the total less the largest and smallest.
    function automatic dist_t mid_two_avg(input dist_t a, input dist_t b,
                                          input dist_t c, input dist_t d);
        dist_t                hi_ab;
        dist_t                lo_ab;
        dist_t                hi_cd;
        dist_t                lo_cd;
        dist_t                hi;
        dist_t                lo;
        logic [DIST_BITS+1:0] total;
        logic [DIST_BITS+1:0] mid;
        hi_ab = (a > b) ? a : b;
        lo_ab = (a > b) ? b : a;
        hi_cd = (c > d) ? c : d;
        lo_cd = (c > d) ? d : c;
        hi    = (hi_ab > hi_cd) ? hi_ab : hi_cd;
        lo    = (lo_ab < lo_cd) ? lo_ab : lo_cd;
        total = (DIST_BITS+2)'(a) + (DIST_BITS+2)'(b) + (DIST_BITS+2)'(c)
              + (DIST_BITS+2)'(d);
        mid   = total - (DIST_BITS+2)'(hi) - (DIST_BITS+2)'(lo);
        return mid[DIST_BITS:1];
    endfunction

    assign o_ok     = !o_v_reg || m_tready;
    assign mv_ok    = !m_v_reg || o_ok;
    assign in_ready = mv_ok;
    assign in_acc   = in_valid && in_ready;

    // The rings already hold this item's distances when it sits in the middle stage.
    always_comb begin
        o_data_next               = '0;
        o_data_next[NUM_CH-1:0]   = m_mask_reg;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            hold_next[ch] = m_mask_reg[ch]
                ? mid_two_avg(hist_reg[ch][0], hist_reg[ch][1],
                              hist_reg[ch][2], hist_reg[ch][3])
                : hold_reg[ch];
            o_data_next[NUM_CH + ch * DIST_BITS +: DIST_BITS] = hold_next[ch];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_v_reg  <= 1'b0;
            o_v_reg  <= 1'b0;
            slot_reg <= '0;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                hold_reg[ch] <= '0;
                for (int s = 0; s < RING_DEPTH; s++) begin
                    hist_reg[ch][s] <= '0;
                end
            end
        end else begin
            if (in_acc) begin
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    if (in_item.mask[ch]) begin
                        hist_reg[ch][slot_reg[ch]] <= in_item.distance[ch];
                        slot_reg[ch]               <= slot_reg[ch] + 1'b1;
                    end
                end
            end
            if (mv_ok) begin
                m_v_reg <= in_valid;
            end
            if (o_ok) begin
                o_v_reg <= m_v_reg;
            end
            if (o_ok && m_v_reg) begin
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    hold_reg[ch] <= hold_next[ch];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mv_ok) begin
            m_mask_reg <= in_item.mask;
        end
        if (o_ok && m_v_reg) begin
            o_data_reg <= o_data_next;
        end
    end

    assign m_tvalid = o_v_reg;
    assign m_tdata  = o_data_reg;

    // Every result reports at least one updated channel.
    a_result_has_update: assert property (@(posedge aclk) disable iff (!aresetn)
        o_v_reg |-> (o_data_reg[NUM_CH-1:0] != '0))
        else $error("result without an updated channel");

    // Ring write pointers move only with an accepted transaction.
    a_slot_only_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_acc |=> $stable(slot_reg))
        else $error("ring pointer moved without a transaction");

    // A filtered item moves into the result register whenever that register is free.
    a_result_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_v_reg && o_ok) |=> o_v_reg)
        else $error("filtered item lost before the result register");

endmodule

`default_nettype wire

>>> dv/epdm_checker.sv
// Stream monitor, distance predictor and result comparison for the echo distance block.
`timescale 1ns / 1ps
`default_nettype none

module epdm_checker
    import epdm_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    input  wire logic                    s_tready,
    input  wire logic [S_TDATA_BITS-1:0] s_tdata,
    input  wire logic                    m_tvalid,
    input  wire logic                    m_tready,
    input  wire logic [M_TDATA_BITS-1:0] m_tdata,
    input  wire logic                    cfg_wr_en,
    input  wire logic [TEMP_BITS-1:0]    cfg_wr_data,
    output logic [31:0]                  mismatch_count = '0,
    output logic [31:0]                  results_seen = '0,
    output logic [31:0]                  results_pending = '0
);

    localparam logic [63:0]          SOUND_BASE    = 64'd3315;
    localparam logic [63:0]          SOUND_PER_DEG = 64'd6;
    localparam logic [63:0]          UM_DIVISOR    = 64'd1600;
    localparam logic [TEMP_BITS-1:0] TEMP_AT_RESET = TEMP_BITS'(20);

    typedef struct packed {
        logic [NUM_CH-1:0]  updated;
        dist_t [NUM_CH-1:0] median;
    } echo_result_t;

    echo_result_t           expected_medians[$];
    logic [NUM_CH-1:0]      last_levels;
    time_t                  rise_stamp [NUM_CH];
    dist_t [RING_DEPTH-1:0] dist_ring [NUM_CH];
    logic [RING_BITS-1:0]   ring_slot [NUM_CH];
    dist_t                  held_median [NUM_CH];
    logic [TEMP_BITS-1:0]   temp_c;

    // Exact scaling by the speed of sound, floored, then clipped to the distance width.
    function automatic dist_t ticks_to_um(input time_t ticks, input logic [TEMP_BITS-1:0] deg);
        logic [63:0] quotient;
        quotient = (64'(ticks) * (SOUND_BASE + SOUND_PER_DEG * 64'(deg))) / UM_DIVISOR;
        return (quotient > 64'(DIST_MAX)) ? DIST_MAX : quotient[DIST_BITS-1:0];
    endfunction

    // The two middle values of four sum to the total less the largest and the smallest.
    function automatic dist_t mid_pair_mean(input dist_t [RING_DEPTH-1:0] vals);
        logic [DIST_BITS+1:0] total;
        dist_t                lo;
        dist_t                hi;
        total = '0;
        lo    = vals[0];
        hi    = vals[0];
        for (int k = 0; k < RING_DEPTH; k++) begin
            total = total + vals[k];
            if (vals[k] < lo) lo = vals[k];
            if (vals[k] > hi) hi = vals[k];
        end
        total = total - lo - hi;
        return total[DIST_BITS:1];
    endfunction

    task automatic predict_medians(input logic [NUM_CH-1:0] levels, input time_t stamp);
        logic [NUM_CH-1:0] rising;
        logic [NUM_CH-1:0] falling;
        echo_result_t      res;
        rising  = levels & ~last_levels;
        falling = ~levels & last_levels;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            if (rising[ch]) rise_stamp[ch] = stamp;
            if (falling[ch]) begin
                dist_ring[ch][ring_slot[ch]] = ticks_to_um(stamp - rise_stamp[ch], temp_c);
                ring_slot[ch]   = ring_slot[ch] + 1'b1;
                held_median[ch] = mid_pair_mean(dist_ring[ch]);
            end
        end
        last_levels = levels;
        if (falling != '0) begin
            res.updated = falling;
            for (int ch = 0; ch < NUM_CH; ch++) res.median[ch] = held_median[ch];
            expected_medians.push_back(res);
        end
    endtask

    task automatic compare_medians(input logic [M_TDATA_BITS-1:0] data);
        echo_result_t want;
        dist_t        got;
        if (expected_medians.size() == 0) begin
            $error("result transaction with nothing expected: %h", data);
            mismatch_count = mismatch_count + 1;
        end else begin
            want = expected_medians.pop_front();
            if (data[NUM_CH-1:0] !== want.updated) begin
                $error("updated_channels: expected %h, actual %h", want.updated, data[NUM_CH-1:0]);
                mismatch_count = mismatch_count + 1;
            end
            for (int ch = 0; ch < NUM_CH; ch++) begin
                got = data[NUM_CH + DIST_BITS * ch +: DIST_BITS];
                if (got !== want.median[ch]) begin
                    $error("median_ch%0d: expected %0d, actual %0d", ch, want.median[ch], got);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_medians.delete();
            last_levels = '0;
            temp_c      = TEMP_AT_RESET;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                rise_stamp[ch]  = '0;
                dist_ring[ch]   = '0;
                ring_slot[ch]   = '0;
                held_median[ch] = '0;
            end
        end else begin
            // A result can never stem from the input taken at the same edge.
            if (m_tvalid && m_tready) begin
                compare_medians(m_tdata);
                results_seen = results_seen + 1;
            end
            if (cfg_wr_en) temp_c = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                predict_medians(s_tdata[NUM_CH-1:0], s_tdata[NUM_CH +: TIME_BITS]);
            end
        end
        results_pending = expected_medians.size();
    end

endmodule

`default_nettype wire

>>> dv/tb_echo_pulse_distance_median4.sv
// Testbench top: stimulus, stream pacing, watchdog and verdict for the echo distance block.
`timescale 1ns / 1ps
`default_nettype none

module tb_echo_pulse_distance_median4;
    import epdm_pkg::*;

    // Random items per temperature setting; six settings give about 1600 in total.
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 263;
    // The pipeline is five stages deep ahead of the output register; the settle time covers both.
    localparam int PIPE_SETTLE     = 8;
    // Longest honest quiet spell is a long sender gap plus a long receiver stall.
    localparam int WATCHDOG_LIMIT  = 2000;

    logic                    aclk        = 1'b0;
    logic                    aresetn     = 1'b0;
    logic                    s_tvalid    = 1'b0;
    logic [S_TDATA_BITS-1:0] s_tdata     = '0;
    logic                    m_tready    = 1'b0;
    logic                    cfg_wr_en   = 1'b0;
    logic [TEMP_BITS-1:0]    cfg_wr_data = '0;
    wire logic               s_tready;
    wire logic               m_tvalid;
    wire logic [M_TDATA_BITS-1:0] m_tdata;

    wire logic [31:0] mismatch_count;
    wire logic [31:0] results_seen;
    wire logic [31:0] results_pending;

    // Pacing controls: a steady side never idles, which gives long back-to-back runs.
    bit sender_steady   = 1'b0;
    bit receiver_steady = 1'b0;
    int ready_left      = 0;
    int stall_cycles    = 0;
    int items_sent      = 0;

    // Running state of the four echo lines and the free-running timestamp.
    logic [NUM_CH-1:0] lines_now = '0;
    time_t             stamp_now = '0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    echo_pulse_distance_median4 i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // The checker sees the same pins as the block and keeps its own model of it.
    epdm_checker i_distance_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (mismatch_count),
        .results_seen   (results_seen),
        .results_pending(results_pending)
    );

    // Receiver back-pressure: short ready bursts broken by stalls that are mostly
    // short and sometimes long. Only one assignment to m_tready happens per edge.
    always @(posedge aclk) begin
        if (ready_left > 0) begin
            ready_left = ready_left - 1;
        end else if (receiver_steady) begin
            m_tready   <= 1'b1;
            ready_left = $urandom_range(5, 60);
        end else if ($urandom_range(0, 2) == 0) begin
            m_tready   <= 1'b0;
            ready_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
                                                      : $urandom_range(10, 40);
        end else begin
            m_tready   <= 1'b1;
            ready_left = $urandom_range(0, 8);
        end
    end

    // Watchdog: count cycles in which neither channel completes a transaction.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[echo_pulse_distance_median4] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Present one input transaction and hold it until the block takes it. An
    // optional gap comes first; without one, s_tvalid simply stays high.
    task automatic send_echo(input logic [NUM_CH-1:0] levels, input time_t stamp);
        int gap;
        gap = 0;
        if (!sender_steady) begin
            if ($urandom_range(0, 99) >= 55) begin
                gap = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3)
                                                   : $urandom_range(8, 40);
            end
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_BITS - NUM_CH - TIME_BITS){1'b0}}, stamp, levels};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // One isolated pulse on the given lines: a rising edge, then a falling edge
    // the requested number of ticks later.
    task automatic echo_pulse(input logic [NUM_CH-1:0] lines, input time_t start,
                              input time_t width);
        send_echo(lines, start);
        send_echo('0, start + width);
    endtask

    // Stop sending and wait until every predicted result has come out. The first
    // edge lets the checker record the last transaction before its queue is read;
    // the settle time then covers inputs that produce no result but are in flight.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    task automatic write_temperature(input logic [TEMP_BITS-1:0] deg);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= deg;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        logic [TEMP_BITS-1:0] phase_temp [NUM_PHASES];
        int                   pick;
        time_t                ring_widths [4];

        // Temperatures: both ends of the range, the out-of-range maximum, the
        // reset value written explicitly, and two random settings.
        phase_temp[0] = TEMP_BITS'(0);
        phase_temp[1] = TEMP_BITS'(63);
        phase_temp[2] = TEMP_BITS'(60);
        phase_temp[3] = TEMP_BITS'($urandom_range(1, 59));
        phase_temp[4] = TEMP_BITS'(20);
        phase_temp[5] = TEMP_BITS'($urandom_range(0, 63));
        ring_widths[0] = 32'd10;
        ring_widths[1] = 32'd5000;
        ring_widths[2] = 32'd300000;
        ring_widths[3] = 32'd9999999;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset temperature. All lines low produces nothing.
        send_echo(4'h0, 32'd0);
        // All four lines rise and fall together with zero width.
        send_echo(4'hF, 32'd100);
        send_echo(4'h0, 32'd100);
        // Single-channel pulses: plain, across the timestamp wrap, and full scale.
        echo_pulse(4'h1, 32'd5, 32'd1600);
        echo_pulse(4'h2, 32'hFFFF_FFF0, 32'h20);
        echo_pulse(4'h4, 32'd0, 32'hFFFF_FFFF);
        echo_pulse(4'h8, 32'd1000, 32'd8096);
        // Just below and just above the saturation point at 20 degrees.
        echo_pulse(4'h8, 32'd0, 32'd7814714);
        echo_pulse(4'h8, 32'd0, 32'd7814715);
        // Wrap the ring of channel 0 with widely different distances.
        for (int k = 0; k < 4; k++) echo_pulse(4'h1, 32'd20000 * (k + 1), ring_widths[k]);
        // Rises and falls in the same transaction on different channels.
        send_echo(4'hA, 32'd50);
        send_echo(4'h5, 32'd4000);
        send_echo(4'h0, 32'd9000);
        lines_now = '0;
        stamp_now = 32'd9000;

        for (int p = 0; p < NUM_PHASES; p++) begin
            // The register is only touched once the pipeline is empty.
            drain_results();
            write_temperature(phase_temp[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 40 == 0) begin
                    sender_steady   = ($urandom_range(0, 3) == 0);
                    receiver_steady = ($urandom_range(0, 3) == 0);
                end
                // Halfway through, the sender holds off until all results are out.
                if (n == ITEMS_PER_PHASE / 2) drain_results();
                // Mostly a few lines toggle, so pulses span several transactions;
                // now and then the line pattern is drawn afresh.
                if ($urandom_range(0, 99) < 80) begin
                    lines_now = lines_now ^ NUM_CH'($urandom_range(0, 15) & $urandom_range(0, 15));
                end else begin
                    lines_now = NUM_CH'($urandom_range(0, 15));
                end
                // Time steps from tiny to large straddle the saturation width; an
                // occasional jump randomizes every timestamp bit and forces wraps.
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    stamp_now = stamp_now + $urandom_range(0, 3000);
                end else if (pick < 80) begin
                    stamp_now = stamp_now + $urandom_range(0, 1 << 20);
                end else if (pick < 95) begin
                    stamp_now = stamp_now + $urandom_range(0, 1 << 24);
                end else begin
                    stamp_now = $urandom();
                end
                send_echo(lines_now, stamp_now);
            end
        end

        drain_results();
        $display("Sent %0d input transactions and checked %0d results.",
                 items_sent, results_seen);
        $display("Temperatures covered the reset value, 0, 60, 63 and random settings.");
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("[echo_pulse_distance_median4] OK");
        end else begin
            $display("[echo_pulse_distance_median4] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
